FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files. Every module that uses them
// has a clock named clk and a synchronous active-high reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define TDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/tds_pkg.sv
`default_nettype none

package tds_pkg;

  localparam int CompW    = 16;
  localparam int VecW     = 3 * CompW;
  localparam int ProdW    = 2 * CompW;
  localparam int SumW     = ProdW + 1;
  localparam int MagW     = ProdW;
  localparam int RestW    = 16;
  localparam int QuoW     = 33;
  localparam int DivSteps = QuoW;
  localparam int NumLanes = 4;
  localparam int MinDetW  = 31;
  localparam int OutW     = 32;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  localparam logic [MinDetW-1:0] MinDetReset = MinDetW'(1);
  localparam logic [OutW-1:0]    SatPos      = {1'b0, {(OutW-1){1'b1}}};
  localparam logic [OutW-1:0]    SatNeg      = {1'b1, {(OutW-1){1'b0}}};

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic [MagW-1:0]         mag_t;
  typedef logic [QuoW-1:0]         quo_t;

  typedef struct packed {
    logic                valid;
    logic                degen;
    logic [NumLanes-1:0] neg;
    mag_t                divisor;
    mag_t [NumLanes-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic                valid;
    logic                degen;
    logic [NumLanes-1:0] neg;
    logic [NumLanes-1:0] ovf;
    quo_t [NumLanes-1:0] quo;
  } div_res_t;

  function automatic comp_t vec_comp(input logic [VecW-1:0] vec, input logic [1:0] idx);
    comp_t c;
    unique case (idx)
      AxisX:   c = vec[0*CompW +: CompW];
      AxisY:   c = vec[1*CompW +: CompW];
      AxisZ:   c = vec[2*CompW +: CompW];
      default: c = vec[0*CompW +: CompW];
    endcase
    return c;
  endfunction

  function automatic logic [CompW-1:0] comp_mag(input comp_t c);
    return c[CompW-1] ? CompW'(-c) : CompW'(c);
  endfunction

  function automatic mag_t sum_mag(input logic signed [SumW-1:0] x);
    logic signed [SumW-1:0] n;
    n = -x;
    return x[SumW-1] ? n[MagW-1:0] : x[MagW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tds_setup.sv
`default_nettype none

`include "assert_macros.svh"

module tds_setup (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [tds_pkg::VecW-1:0]      normal_vec,
  input  wire logic [tds_pkg::VecW-1:0]      tangent_s,
  input  wire logic [tds_pkg::VecW-1:0]      tangent_t,
  input  wire logic [tds_pkg::VecW-1:0]      ray_dx,
  input  wire logic [tds_pkg::VecW-1:0]      ray_dy,
  input  wire logic [tds_pkg::MinDetW-1:0]   min_det,
  output tds_pkg::div_req_t                  req
);

  logic [tds_pkg::CompW-1:0] nx, ny, nz;
  logic [1:0]                ax_u, ax_v;

  logic          s0_valid;
  tds_pkg::comp_t a00, a10, a01, a11, bx0, bx1, by0, by1;

  logic s1_valid;
  logic signed [tds_pkg::ProdW-1:0] p_a00a11, p_a01a10;
  logic signed [tds_pkg::ProdW-1:0] p_a11bx0, p_a01bx1, p_a00bx1, p_a10bx0;
  logic signed [tds_pkg::ProdW-1:0] p_a11by0, p_a01by1, p_a00by1, p_a10by0;

  logic s2_valid;
  logic signed [tds_pkg::SumW-1:0] det;
  logic signed [tds_pkg::SumW-1:0] num [tds_pkg::NumLanes];

  tds_pkg::mag_t abs_det;

  always_comb begin
    nx = tds_pkg::comp_mag(tds_pkg::vec_comp(normal_vec, tds_pkg::AxisX));
    ny = tds_pkg::comp_mag(tds_pkg::vec_comp(normal_vec, tds_pkg::AxisY));
    nz = tds_pkg::comp_mag(tds_pkg::vec_comp(normal_vec, tds_pkg::AxisZ));
    priority if (nx > ny && nx > nz) begin
      ax_u = tds_pkg::AxisY;
      ax_v = tds_pkg::AxisZ;
    end else if (ny > nz) begin
      ax_u = tds_pkg::AxisX;
      ax_v = tds_pkg::AxisZ;
    end else begin
      ax_u = tds_pkg::AxisX;
      ax_v = tds_pkg::AxisY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      req.valid <= 1'b0;
    end else begin
      s0_valid <= in_valid;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      req.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    a00 <= tds_pkg::vec_comp(tangent_s, ax_u);
    a10 <= tds_pkg::vec_comp(tangent_s, ax_v);
    a01 <= tds_pkg::vec_comp(tangent_t, ax_u);
    a11 <= tds_pkg::vec_comp(tangent_t, ax_v);
    bx0 <= tds_pkg::vec_comp(ray_dx, ax_u);
    bx1 <= tds_pkg::vec_comp(ray_dx, ax_v);
    by0 <= tds_pkg::vec_comp(ray_dy, ax_u);
    by1 <= tds_pkg::vec_comp(ray_dy, ax_v);
  end

  always_ff @(posedge clk) begin
    p_a00a11 <= tds_pkg::ProdW'(a00) * tds_pkg::ProdW'(a11);
    p_a01a10 <= tds_pkg::ProdW'(a01) * tds_pkg::ProdW'(a10);
    p_a11bx0 <= tds_pkg::ProdW'(a11) * tds_pkg::ProdW'(bx0);
    p_a01bx1 <= tds_pkg::ProdW'(a01) * tds_pkg::ProdW'(bx1);
    p_a00bx1 <= tds_pkg::ProdW'(a00) * tds_pkg::ProdW'(bx1);
    p_a10bx0 <= tds_pkg::ProdW'(a10) * tds_pkg::ProdW'(bx0);
    p_a11by0 <= tds_pkg::ProdW'(a11) * tds_pkg::ProdW'(by0);
    p_a01by1 <= tds_pkg::ProdW'(a01) * tds_pkg::ProdW'(by1);
    p_a00by1 <= tds_pkg::ProdW'(a00) * tds_pkg::ProdW'(by1);
    p_a10by0 <= tds_pkg::ProdW'(a10) * tds_pkg::ProdW'(by0);
  end

  always_ff @(posedge clk) begin
    det    <= tds_pkg::SumW'(p_a00a11) - tds_pkg::SumW'(p_a01a10);
    num[0] <= tds_pkg::SumW'(p_a11bx0) - tds_pkg::SumW'(p_a01bx1);
    num[1] <= tds_pkg::SumW'(p_a00bx1) - tds_pkg::SumW'(p_a10bx0);
    num[2] <= tds_pkg::SumW'(p_a11by0) - tds_pkg::SumW'(p_a01by1);
    num[3] <= tds_pkg::SumW'(p_a00by1) - tds_pkg::SumW'(p_a10by0);
  end

  assign abs_det = tds_pkg::sum_mag(det);

  always_ff @(posedge clk) begin
    req.degen   <= (det == '0) || (abs_det < tds_pkg::MagW'(min_det));
    req.divisor <= abs_det;
    for (int k = 0; k < tds_pkg::NumLanes; k++) begin
      req.neg[k]      <= num[k][tds_pkg::SumW-1] ^ det[tds_pkg::SumW-1];
      req.dividend[k] <= tds_pkg::sum_mag(num[k]);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tds_divider.sv
`default_nettype none

`include "assert_macros.svh"

module tds_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire tds_pkg::div_req_t req,
  output tds_pkg::div_res_t res
);

  localparam int N = tds_pkg::DivSteps;

  logic                                          st_valid [0:N];
  logic                                          st_degen [0:N];
  logic [tds_pkg::NumLanes-1:0]                  st_neg   [0:N];
  logic [tds_pkg::NumLanes-1:0]                  st_ovf   [0:N];
  tds_pkg::mag_t                                 st_div   [0:N];
  tds_pkg::mag_t [tds_pkg::NumLanes-1:0]         st_rem   [0:N];
  logic [tds_pkg::NumLanes-1:0][tds_pkg::RestW-1:0] st_rest [0:N];
  tds_pkg::quo_t [tds_pkg::NumLanes-1:0]         st_quo   [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else begin
      st_valid[0] <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    st_degen[0] <= req.degen;
    st_neg[0]   <= req.neg;
    st_div[0]   <= req.divisor;
    for (int k = 0; k < tds_pkg::NumLanes; k++) begin
      st_rem[0][k]  <= tds_pkg::MagW'(req.dividend[k][tds_pkg::MagW-1:tds_pkg::RestW]);
      st_rest[0][k] <= req.dividend[k][tds_pkg::RestW-1:0];
      st_ovf[0][k]  <= tds_pkg::MagW'(req.dividend[k][tds_pkg::MagW-1:tds_pkg::RestW])
                       >= req.divisor;
      st_quo[0][k]  <= '0;
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_step
    logic [tds_pkg::MagW:0]       trial [tds_pkg::NumLanes];
    logic [tds_pkg::MagW+1:0]     diff  [tds_pkg::NumLanes];
    logic [tds_pkg::NumLanes-1:0] ge;

    always_comb begin
      for (int k = 0; k < tds_pkg::NumLanes; k++) begin
        trial[k] = {st_rem[s][k], st_rest[s][k][tds_pkg::RestW-1]};
        diff[k]  = {1'b0, trial[k]} - {2'b00, st_div[s]};
        ge[k]    = !diff[k][tds_pkg::MagW+1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s+1] <= 1'b0;
      end else begin
        st_valid[s+1] <= st_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      st_degen[s+1] <= st_degen[s];
      st_neg[s+1]   <= st_neg[s];
      st_ovf[s+1]   <= st_ovf[s];
      st_div[s+1]   <= st_div[s];
      for (int k = 0; k < tds_pkg::NumLanes; k++) begin
        st_rem[s+1][k]  <= ge[k] ? diff[k][tds_pkg::MagW-1:0] : trial[k][tds_pkg::MagW-1:0];
        st_rest[s+1][k] <= {st_rest[s][k][tds_pkg::RestW-2:0], 1'b0};
        st_quo[s+1][k]  <= {st_quo[s][k][tds_pkg::QuoW-2:0], ge[k]};
      end
    end
  end

  always_comb begin
    res.valid = st_valid[N];
    res.degen = st_degen[N];
    res.neg   = st_neg[N];
    res.ovf   = st_ovf[N];
    res.quo   = st_quo[N];
  end

  `TDS_ASSERT_IMP(rem_below_divisor, st_valid[N],
    (st_ovf[N][0] || st_rem[N][0] < st_div[N]) &&
    (st_ovf[N][1] || st_rem[N][1] < st_div[N]) &&
    (st_ovf[N][2] || st_rem[N][2] < st_div[N]) &&
    (st_ovf[N][3] || st_rem[N][3] < st_div[N]),
    "Divider remainder is not below the divisor.")

endmodule

`default_nettype wire

FILE: rtl/tds_finish.sv
`default_nettype none

`include "assert_macros.svh"

module tds_finish (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tds_pkg::div_res_t             res,
  output logic                               done,
  output logic [tds_pkg::NumLanes-1:0][tds_pkg::OutW-1:0] result,
  output logic                               degenerate,
  output logic                               saturated
);

  logic [tds_pkg::QuoW:0]       rsum [tds_pkg::NumLanes];
  tds_pkg::quo_t                qr   [tds_pkg::NumLanes];
  logic [tds_pkg::NumLanes-1:0] sat_c;

  logic                                    a_valid;
  logic                                    a_degen;
  logic [tds_pkg::NumLanes-1:0]            a_neg;
  logic [tds_pkg::NumLanes-1:0]            a_sat;
  logic [tds_pkg::NumLanes-1:0][tds_pkg::OutW-1:0] a_mag;

  always_comb begin
    for (int k = 0; k < tds_pkg::NumLanes; k++) begin
      rsum[k]  = {1'b0, res.quo[k]} + (tds_pkg::QuoW+1)'(1);
      qr[k]    = rsum[k][tds_pkg::QuoW:1];
      sat_c[k] = res.ovf[k] ||
                 (res.neg[k] ? (qr[k] > tds_pkg::QuoW'(tds_pkg::SatNeg))
                             : (qr[k] > tds_pkg::QuoW'(tds_pkg::SatPos)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      a_valid <= res.valid;
      done    <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_degen <= res.degen;
    a_neg   <= res.neg;
    a_sat   <= sat_c;
    for (int k = 0; k < tds_pkg::NumLanes; k++) begin
      if (sat_c[k]) begin
        a_mag[k] <= res.neg[k] ? tds_pkg::SatNeg : tds_pkg::SatPos;
      end else begin
        a_mag[k] <= qr[k][tds_pkg::OutW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    degenerate <= a_degen;
    saturated  <= !a_degen && (|a_sat);
    for (int k = 0; k < tds_pkg::NumLanes; k++) begin
      if (a_degen) begin
        result[k] <= '0;
      end else begin
        result[k] <= a_neg[k] ? -a_mag[k] : a_mag[k];
      end
    end
  end

  `TDS_ASSERT_IMP(degen_zeroes_all, done && degenerate,
    result == '0 && !saturated,
    "A degenerate item carries a nonzero field.")

endmodule

`default_nettype wire

FILE: rtl/texture_differential_solve.sv
// Computes the texture-coordinate derivatives (ds/dx, dt/dx, ds/dy, dt/dy) of a ray hit by
// dropping the dominant normal axis and solving the resulting 2x2 system exactly, rounded to
// the nearest Q16.16 step. One item is taken per clock cycle with start while busy is low;
// busy is high only while reset is held and in the cycle after it. The result appears
// with done after the setup registers for axis selection, multiplies and determinant, one
// range check, 33 stages of a one-bit-per-stage restoring divider shared by the four
// quotients, and the registers of rounding, clamping and sign. The receiver cannot stall,
// so every result is on the result ports for exactly one cycle and must be taken then.
// The threshold register may be written whenever no item is in flight; cfg_ready is always
// high.
`default_nettype none

`include "assert_macros.svh"

module texture_differential_solve (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [tds_pkg::VecW-1:0]      normal_vec,
  input  wire logic [tds_pkg::VecW-1:0]      tangent_s,
  input  wire logic [tds_pkg::VecW-1:0]      tangent_t,
  input  wire logic [tds_pkg::VecW-1:0]      ray_dx,
  input  wire logic [tds_pkg::VecW-1:0]      ray_dy,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tds_pkg::MinDetW-1:0]   cfg_data,
  output logic                               done,
  output logic signed [tds_pkg::OutW-1:0]    ds_dx,
  output logic signed [tds_pkg::OutW-1:0]    dt_dx,
  output logic signed [tds_pkg::OutW-1:0]    ds_dy,
  output logic signed [tds_pkg::OutW-1:0]    dt_dy,
  output logic                               degenerate,
  output logic                               saturated
);

  logic [tds_pkg::MinDetW-1:0] min_determinant;
  tds_pkg::div_req_t           req;
  tds_pkg::div_res_t           res;
  logic [tds_pkg::NumLanes-1:0][tds_pkg::OutW-1:0] result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b1;
      min_determinant <= tds_pkg::MinDetReset;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        min_determinant <= cfg_data;
      end
    end
  end

  tds_setup u_setup (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .normal_vec (normal_vec),
    .tangent_s  (tangent_s),
    .tangent_t  (tangent_t),
    .ray_dx     (ray_dx),
    .ray_dy     (ray_dy),
    .min_det    (min_determinant),
    .req        (req)
  );

  tds_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  tds_finish u_finish (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .done       (done),
    .result     (result),
    .degenerate (degenerate),
    .saturated  (saturated)
  );

  assign ds_dx = result[0];
  assign dt_dx = result[1];
  assign ds_dy = result[2];
  assign dt_dy = result[3];

  `TDS_ASSERT(no_flag_clash, done |-> !(degenerate && saturated),
    "An item is flagged both degenerate and saturated.")
  `TDS_ASSERT_IMP(busy_only_after_reset, $past(rst) == 1'b0, !busy,
    "Busy is high outside the cycle after reset.")

endmodule

`default_nettype wire
